FILE: hdl/assert_macros.svh
// Assertion macros used by the cross stencil counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define CSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/csc_pkg.sv
// Shared constants, types and helpers of the cross stencil threshold counter.
package csc_pkg;

    localparam int MAX_COLUMNS   = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int PIXEL_BITS    = 8;

    localparam int COL_BITS      = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS      = $clog2(MAX_ROWS);
    localparam int PIXEL_IN_BITS = 8;
    localparam int THRESH_BITS   = 8;
    localparam int DIM_BITS      = 11;
    localparam int COUNT_BITS    = 20;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = DIM_BITS;
    localparam int DIM_MIN       = 3;
    localparam int SUM_BITS      = ((PIXEL_BITS > THRESH_BITS) ? PIXEL_BITS : THRESH_BITS) + 3;
    localparam int WIN_CELLS     = 3;

    localparam logic [THRESH_BITS-1:0] THRESH_RST = 8'd6;
    localparam logic [DIM_BITS-1:0]    COLS_RST   = 11'd8;
    localparam logic [DIM_BITS-1:0]    ROWS_RST   = 11'd6;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [SUM_BITS-1:0]   t_sum;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_AVG_THRESHOLD,
        CFG_FRAME_COLUMNS,
        CFG_FRAME_ROWS
    } t_cfg_idx;

    // One line buffer entry: the two rows above the current one.
    typedef struct packed {
        t_pix older;
        t_pix prev;
    } t_lb_entry;

    typedef struct packed {
        logic en;
        t_col col;
    } t_lb_rd;

    typedef struct packed {
        logic      en;
        t_col      col;
        t_lb_entry entry;
    } t_lb_wr;

    // Last column index for a programmed width, clamped to the legal range.
    function automatic t_col cols_last(input logic [DIM_BITS-1:0] v);
        t_col res;
        if (v < DIM_BITS'(DIM_MIN)) begin
            res = COL_BITS'(DIM_MIN - 1);
        end else if (32'(v) > MAX_COLUMNS) begin
            res = COL_BITS'(MAX_COLUMNS - 1);
        end else begin
            res = COL_BITS'(v - DIM_BITS'(1));
        end
        return res;
    endfunction

    // Last row index for a programmed height, clamped to the legal range.
    function automatic t_row rows_last(input logic [DIM_BITS-1:0] v);
        t_row res;
        if (v < DIM_BITS'(DIM_MIN)) begin
            res = ROW_BITS'(DIM_MIN - 1);
        end else if (32'(v) > MAX_ROWS) begin
            res = ROW_BITS'(MAX_ROWS - 1);
        end else begin
            res = ROW_BITS'(v - DIM_BITS'(1));
        end
        return res;
    endfunction

endpackage

FILE: hdl/csc_pixel_if.sv
// Pixel word channel: valid, ready and one pixel.
interface csc_pixel_if import csc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PIXEL_IN_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: hdl/csc_count_if.sv
// Frame total word channel: valid, ready and the star count.
interface csc_count_if import csc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] star_count;

    modport source (output valid, output star_count, input ready);
    modport sink   (input valid, input star_count, output ready);
endinterface

FILE: hdl/csc_cell.sv
// One window cell: holds the middle-row pixel of one column of the cross.
module csc_cell import csc_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  logic i_load,
    input  t_pix i_load_val,
    input  t_pix i_nbr_val,
    output t_pix o_val
);

    t_pix r_val;
    t_pix n_val;

    // Take a fresh column from the line buffer or shift in from the right.
    always_comb begin
        n_val = i_load ? i_load_val : i_nbr_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

FILE: hdl/csc_line_buf.sv
// Two-row line buffer: one write port, two registered read ports, write bypass.
module csc_line_buf import csc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lb_rd    i_rd,
    input  t_lb_wr    i_wr,
    output t_lb_entry o_center,
    output t_pix      o_right_prev
);

    t_lb_entry r_mem [MAX_COLUMNS];
    t_lb_entry r_rd_c;
    t_lb_entry r_rd_r;
    t_col      r_rd_col;
    logic      r_wr_vld;
    t_col      r_wr_col;
    t_lb_entry r_wr_entry;
    t_col      w_rd_next;
    t_col      w_rd_col_next;

    assign w_rd_next     = i_rd.col + COL_BITS'(1);
    assign w_rd_col_next = r_rd_col + COL_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_c   <= r_mem[i_rd.col];
            r_rd_r   <= r_mem[w_rd_next];
            r_rd_col <= i_rd.col;
        end
        if (i_wr.en) begin
            r_mem[i_wr.col] <= i_wr.entry;
            r_wr_col        <= i_wr.col;
            r_wr_entry      <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_wr_vld <= 1'b1;
        end
    end

    // A write at the read edge is missed by the array read: forward it.
    always_comb begin
        o_center     = r_rd_c;
        o_right_prev = r_rd_r.prev;
        if (r_wr_vld && (r_wr_col == r_rd_col)) begin
            o_center = r_wr_entry;
        end
        if (r_wr_vld && (r_wr_col == w_rd_col_next)) begin
            o_right_prev = r_wr_entry.prev;
        end
    end

endmodule

FILE: hdl/cross_stencil_threshold_counter_core.sv
// Top level of the five-point cross stencil threshold counter.
//
// Takes a frame of pixels in row-major order, one word per clock, and counts
// the interior pixels whose five-point cross (center, up, down, left, right)
// sums to more than five times avg_threshold. With the last pixel of a frame
// the frame total leaves on the count channel and the count restarts at zero.
// Rate: one word per cycle while ready is high. A frame's last pixel passes
// the read, window and compare stages before its total is on o_cnt. The
// input drops ready only while a new frame total is ready and the previous
// one still sits unread in the output register. The two previous rows live
// in one line buffer of MAX_COLUMNS entries (older and previous row per
// column), read at the current and next column, written back from stage 1.
// The window is a chain of three column cells (left, center, right) holding
// the previous-row pixels; the left cell is the center shifted from the pixel
// before. The line buffer has no reset and no clearing pass: its entries are
// written by the first rows of a frame before a cross ever reads them.
// The user writes configuration (threshold, columns, rows) through i_cfg_we
// only while no pixel is in flight; the block does not enforce this. Frame
// sizes below three act as three and above the maximum act as the maximum,
// and a narrowed size holds the position at the new last column or row.
module cross_stencil_threshold_counter_core import csc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    csc_pixel_if.sink                i_pix,
    csc_count_if.source              o_cnt,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // configuration
    logic [THRESH_BITS-1:0] r_thr;
    t_col                   r_cols_last;
    t_row                   r_rows_last;

    // position of the next pixel
    t_col r_col;
    t_row r_row;

    // stage 1: line buffer read in flight
    logic r_s1_vld;
    logic r_s1_eval;
    logic r_s1_last;
    t_pix r_s1_px;
    t_col r_s1_col;

    // stage 2: window loaded
    logic r_s2_vld;
    logic r_s2_eval;
    logic r_s2_last;
    t_pix r_s2_up;
    t_pix r_s2_down;

    // stage 3: compare result
    logic r_s3_vld;
    logic r_s3_hit;
    logic r_s3_last;

    // frame total and output word
    t_count r_total;
    t_count n_total;
    logic   r_out_vld;
    t_count r_out_cnt;

    logic      w_en;
    logic      w_accept;
    t_pix      w_px;
    t_col      w_col;
    t_row      w_row;
    logic      w_last_col;
    logic      w_last_row;
    logic      w_eval;
    t_lb_rd    w_lb_rd;
    t_lb_wr    w_lb_wr;
    t_lb_entry w_center;
    t_pix      w_right_prev;
    t_pix      w_cell_out  [WIN_CELLS];
    t_pix      w_cell_load [WIN_CELLS];
    t_pix      w_cell_nbr  [WIN_CELLS];
    t_sum      w_sum;
    t_sum      w_thr5;
    logic      w_hit;

    // Hold the whole pipeline only when a frame total meets a full output.
    assign w_en        = !(r_s3_vld && r_s3_last && r_out_vld && !o_cnt.ready);
    assign i_pix.ready = w_en;
    assign w_accept    = i_pix.valid && w_en;
    assign w_px        = PIXEL_BITS'(i_pix.pixel);

    // Clamp the position to the current frame size.
    assign w_col      = (r_col > r_cols_last) ? r_cols_last : r_col;
    assign w_row      = (r_row > r_rows_last) ? r_rows_last : r_row;
    assign w_last_col = (w_col == r_cols_last);
    assign w_last_row = (w_row == r_rows_last);
    // Interior center one row up: needs two rows above and a column each side.
    assign w_eval     = (w_row >= ROW_BITS'(2)) && (w_col != '0) && !w_last_col;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESH_RST;
            r_cols_last <= cols_last(COLS_RST);
            r_rows_last <= rows_last(ROWS_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AVG_THRESHOLD: r_thr       <= i_cfg_data[THRESH_BITS-1:0];
                CFG_FRAME_COLUMNS: r_cols_last <= cols_last(i_cfg_data[DIM_BITS-1:0]);
                CFG_FRAME_ROWS:    r_rows_last <= rows_last(i_cfg_data[DIM_BITS-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Advance the raster position on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : (w_row + ROW_BITS'(1));
            end else begin
                r_col <= w_col + COL_BITS'(1);
                r_row <= w_row;
            end
        end
    end

    // Line buffer: read current and next column, write back from stage 1.
    assign w_lb_rd.en  = w_en;
    assign w_lb_rd.col = w_col;

    assign w_lb_wr.en          = w_en && r_s1_vld;
    assign w_lb_wr.col         = r_s1_col;
    assign w_lb_wr.entry.older = w_center.prev;
    assign w_lb_wr.entry.prev  = r_s1_px;

    csc_line_buf u_line_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd         (w_lb_rd),
        .i_wr         (w_lb_wr),
        .o_center     (w_center),
        .o_right_prev (w_right_prev)
    );

    // Window chain: the right and center cells load from the line buffer,
    // the left cell takes the center of the previous pixel.
    for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
        if (k == WIN_CELLS - 1) begin : g_right
            assign w_cell_load[k] = w_right_prev;
            assign w_cell_nbr[k]  = w_right_prev;
        end else begin : g_inner
            assign w_cell_load[k] = w_center.prev;
            assign w_cell_nbr[k]  = w_cell_out[k+1];
        end

        csc_cell u_cell (
            .i_clk      (i_clk),
            .i_en       (w_en && r_s1_vld),
            .i_load     (k != 0),
            .i_load_val (w_cell_load[k]),
            .i_nbr_val  (w_cell_nbr[k]),
            .o_val      (w_cell_out[k])
        );
    end

    // Cross sum against five times the threshold.
    always_comb begin
        w_sum = SUM_BITS'(r_s2_up) + SUM_BITS'(r_s2_down);
        for (int k = 0; k < WIN_CELLS; k++) begin
            w_sum = w_sum + SUM_BITS'(w_cell_out[k]);
        end
        w_thr5 = (SUM_BITS'(r_thr) << 2) + SUM_BITS'(r_thr);
        w_hit  = r_s2_eval && (w_sum > w_thr5);
    end

    // Saturating frame count.
    always_comb begin
        n_total = r_total;
        if (r_s3_hit && (r_total != '1)) begin
            n_total = r_total + COUNT_BITS'(1);
        end
    end

    // Pipeline valid and control bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_s1_vld <= w_accept;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
                if (r_s3_vld) begin
                    r_total <= r_s3_last ? '0 : n_total;
                end
            end
            if (w_en && r_s3_vld && r_s3_last) begin
                r_out_vld <= 1'b1;
            end else if (o_cnt.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_eval <= w_eval;
            r_s1_last <= w_last_col && w_last_row;
            r_s1_px   <= w_px;
            r_s1_col  <= w_col;
            r_s2_eval <= r_s1_vld && r_s1_eval;
            r_s2_last <= r_s1_last;
            r_s2_up   <= w_center.older;
            r_s2_down <= r_s1_px;
            r_s3_hit  <= w_hit;
            r_s3_last <= r_s2_last;
            if (r_s3_vld && r_s3_last) begin
                r_out_cnt <= n_total;
            end
        end
    end

    assign o_cnt.valid      = r_out_vld;
    assign o_cnt.star_count = r_out_cnt;

`include "assert_macros.svh"

    `CSC_ASSERT_NEXT(a_col_wraps, w_accept && w_last_col, r_col == '0, "column did not wrap")
    `CSC_ASSERT_NEXT(a_total_clears, w_en && r_s3_vld && r_s3_last, r_total == '0, "total kept")
    `CSC_ASSERT_NOW(a_out_from_last, $rose(r_out_vld), $past(w_en && r_s3_vld && r_s3_last), "stray total")

endmodule

FILE: dv/cross_stencil_threshold_counter_core_tb.sv
// Self-checking testbench for the five-point cross stencil threshold counter core.
module cross_stencil_threshold_counter_core_tb;
    import csc_pkg::*;

    // Cycles to let pass after the last word before touching the register port;
    // the core carries a frame's last pixel through its stages before its total.
    localparam int DRAIN_CYCLES  = 6;
    // Length of the long receiver hold-off that backs up the core.
    localparam int HOLD_CYCLES   = 150;
    // Random stimulus goes on until all of these have been reached.
    localparam int RANDOM_PIXELS = 220;
    localparam int RANDOM_FRAMES = 8;
    localparam int MIN_PHASES    = 4;

    // Frame counter model: line buffers, raster position and the running star
    // total, plus the queue of frame totals still to come out of the core.
    class frame_star_scoreboard;
        logic [THRESH_BITS-1:0] thresh_reg;
        logic [DIM_BITS-1:0]    cols_reg;
        logic [DIM_BITS-1:0]    rows_reg;
        bit [PIXEL_BITS-1:0]    older_line [MAX_COLUMNS];
        bit [PIXEL_BITS-1:0]    prev_line [MAX_COLUMNS];
        int unsigned            row_pos;
        int unsigned            col_pos;
        t_count                 frame_total;
        t_count                 expected_totals [$];
        int unsigned            errors;
        int unsigned            frames_checked;
        int unsigned            pixels_seen;

        function new();
            thresh_reg     = THRESH_RST;
            cols_reg       = COLS_RST;
            rows_reg       = ROWS_RST;
            row_pos        = 0;
            col_pos        = 0;
            frame_total    = '0;
            errors         = 0;
            frames_checked = 0;
            pixels_seen    = 0;
        endfunction

        function int unsigned dim_in_use(logic [DIM_BITS-1:0] v, int unsigned maxv);
            if (v < DIM_MIN) return DIM_MIN;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int unsigned cols_in_use();
            return dim_in_use(cols_reg, MAX_COLUMNS);
        endfunction

        function int unsigned rows_in_use();
            return dim_in_use(rows_reg, MAX_ROWS);
        endfunction

        function int unsigned frame_pixels();
            return cols_in_use() * rows_in_use();
        endfunction

        // Pixels still needed to close the current frame; a position past a
        // narrowed size counts as the last column or row.
        function int unsigned pixels_left();
            int unsigned ncols, nrows, c, r;
            ncols = cols_in_use();
            nrows = rows_in_use();
            c = (col_pos > ncols - 1) ? ncols - 1 : col_pos;
            r = (row_pos > nrows - 1) ? nrows - 1 : row_pos;
            return (nrows - 1 - r) * ncols + (ncols - c);
        endfunction

        function int unsigned pending();
            return expected_totals.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_AVG_THRESHOLD: thresh_reg = data[THRESH_BITS-1:0];
                CFG_FRAME_COLUMNS: cols_reg = data;
                CFG_FRAME_ROWS:    rows_reg = data;
                default: ;
            endcase
        endfunction

        // Advance the raster by one accepted pixel; queue the frame total
        // when it closes the frame.
        function void note_pixel(t_pix px);
            int unsigned ncols, nrows, c, r, cross_sum;
            ncols = cols_in_use();
            nrows = rows_in_use();
            c = (col_pos > ncols - 1) ? ncols - 1 : col_pos;
            r = (row_pos > nrows - 1) ? nrows - 1 : row_pos;
            pixels_seen++;
            // The cross centered one row up and at this column is complete.
            // older_line[c-1] was already shifted, so it holds the left pixel.
            if (r >= 2 && c >= 1 && c + 1 <= ncols - 1) begin
                cross_sum = older_line[c-1] + prev_line[c] + prev_line[c+1]
                          + older_line[c] + px;
                if (cross_sum > 5 * thresh_reg && frame_total != '1) frame_total++;
            end
            older_line[c] = prev_line[c];
            prev_line[c]  = px;
            if (c == ncols - 1) begin
                col_pos = 0;
                if (r == nrows - 1) begin
                    expected_totals.push_back(frame_total);
                    frame_total = '0;
                    row_pos     = 0;
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_total(t_count got);
            t_count want;
            if (expected_totals.size() == 0) begin
                $error("star_count: no total expected, actual %0d", got);
                errors++;
            end else begin
                want = expected_totals.pop_front();
                frames_checked++;
                if (got !== want) begin
                    $error("star_count: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    csc_pixel_if pix_if ();
    csc_count_if cnt_if ();

    frame_star_scoreboard sb = new();

    // Idle mix of the current phase, in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit          hold_request   = 1'b0;
    int unsigned phase_count    = 0;

    cross_stencil_threshold_counter_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_cnt      (cnt_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the core hangs or drops a handshake.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: stall at the phase's rate, or hold ready low for one long
    // stretch when asked so that totals back up and the input stalls.
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                cnt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                cnt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Monitor: feed register writes and accepted pixels to the model and
    // check every accepted total against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.pixel);
            if (cnt_if.valid && cnt_if.ready) sb.check_total(cnt_if.star_count);
        end
    end

    // Offer one pixel word after a random idle gap; return at the accepting edge.
    task automatic send_pixel(input t_pix px);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Drop valid, wait for every expected total, then let the pipeline drain.
    task automatic settle();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; the extra edge lets the monitor update the model.
    task automatic program_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly pixels near the threshold so crosses land on both sides of it,
    // with some full-range values and hard extremes mixed in.
    function automatic t_pix pick_pixel();
        int v;
        case ($urandom_range(9))
            0: return t_pix'($urandom_range(255));
            1: return $urandom_range(1) ? '1 : '0;
            default: begin
                v = int'(sb.thresh_reg) - 6 + int'($urandom_range(12));
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return t_pix'(v);
            end
        endcase
    endfunction

    // Send one frame of random pixels. When allowed, stop partway, let the
    // core go idle and change threshold, height, or narrow the width, then
    // finish the frame at the new size. Widening mid-frame is left out: it
    // would read line-buffer columns that the rows above never wrote.
    task automatic send_frame(input bit allow_change);
        int unsigned total, split;
        total = sb.frame_pixels();
        split = (allow_change && $urandom_range(3) == 0) ? $urandom_range(total - 1, 1) : total;
        repeat (split) send_pixel(pick_pixel());
        if (split < total) begin
            settle();
            case ($urandom_range(2))
                0: program_reg(CFG_AVG_THRESHOLD, CFG_DATA_BITS'($urandom_range(255)));
                1: program_reg(CFG_FRAME_ROWS, CFG_DATA_BITS'($urandom_range(8)));
                default: program_reg(CFG_FRAME_COLUMNS,
                                     CFG_DATA_BITS'($urandom_range(sb.cols_in_use())));
            endcase
            repeat (sb.pixels_left()) send_pixel(pick_pixel());
        end
    endtask

    task automatic send_pattern(input t_pix pat [9]);
        foreach (pat[i]) send_pixel(pat[i]);
    endtask

    initial begin
        t_pix all_max [9];
        t_pix just_over [9];
        int unsigned base_pixels, base_frames;

        all_max   = '{default: 8'hFF};
        // Cross sums to 501 against a threshold of 100: counted by one.
        just_over = '{8'd0, 8'd100, 8'd0, 8'd100, 8'd101, 8'd100, 8'd0, 8'd100, 8'd0};

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_AVG_THRESHOLD;
        i_cfg_data   <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: one 8x6 frame at threshold 6 without any write.
        send_frame(1'b0);
        settle();

        // Smallest frame, saturated pixels: sum 1275 beats 5*254 but ties 5*255.
        program_reg(CFG_FRAME_COLUMNS, 11'd3);
        program_reg(CFG_FRAME_ROWS, 11'd3);
        program_reg(CFG_AVG_THRESHOLD, 11'd254);
        send_pattern(all_max);
        settle();
        program_reg(CFG_AVG_THRESHOLD, 11'd255);
        send_pattern(all_max);
        settle();
        program_reg(CFG_AVG_THRESHOLD, 11'd100);
        send_pattern(just_over);
        settle();

        // Clamped sizes: width below three with height past the maximum,
        // then width past the maximum with height below three. Each frame
        // runs well past what a three-wide or three-high frame would hold,
        // then a narrowing write closes it at the new last row or column.
        program_reg(CFG_FRAME_COLUMNS, 11'd0);
        program_reg(CFG_FRAME_ROWS, 11'd2047);
        program_reg(CFG_AVG_THRESHOLD, 11'd0);
        repeat (30) send_pixel(pick_pixel());
        settle();
        program_reg(CFG_FRAME_ROWS, 11'd3);
        repeat (sb.pixels_left()) send_pixel(pick_pixel());
        settle();
        program_reg(CFG_FRAME_COLUMNS, 11'd2047);
        program_reg(CFG_FRAME_ROWS, 11'd1);
        program_reg(CFG_AVG_THRESHOLD, 11'd90);
        repeat (40) send_pixel(pick_pixel());
        settle();
        program_reg(CFG_FRAME_COLUMNS, 11'd3);
        repeat (sb.pixels_left()) send_pixel(pick_pixel());
        settle();

        // Backpressure: hold the receiver off while small frames keep coming,
        // so finished totals pile up and the core stalls its input.
        program_reg(CFG_FRAME_COLUMNS, 11'd3);
        program_reg(CFG_FRAME_ROWS, 11'd3);
        program_reg(CFG_AVG_THRESHOLD, 11'($urandom_range(40, 200)));
        hold_request = 1'b1;
        repeat (8) send_frame(1'b0);
        settle();

        // Random phases, cycling through the idle mixes.
        base_pixels = sb.pixels_seen;
        base_frames = sb.frames_checked;
        while (sb.pixels_seen - base_pixels < RANDOM_PIXELS
               || sb.frames_checked - base_frames < RANDOM_FRAMES
               || phase_count < MIN_PHASES) begin
            case (phase_count % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            settle();
            case ($urandom_range(9))
                0: program_reg(CFG_AVG_THRESHOLD, 11'd0);
                1: program_reg(CFG_AVG_THRESHOLD, 11'd255);
                default: program_reg(CFG_AVG_THRESHOLD, CFG_DATA_BITS'($urandom_range(255)));
            endcase
            case ($urandom_range(9))
                0: program_reg(CFG_FRAME_COLUMNS, CFG_DATA_BITS'($urandom_range(2)));
                1: program_reg(CFG_FRAME_COLUMNS, CFG_DATA_BITS'($urandom_range(24, 11)));
                default: program_reg(CFG_FRAME_COLUMNS, CFG_DATA_BITS'($urandom_range(10, 3)));
            endcase
            case ($urandom_range(9))
                0: program_reg(CFG_FRAME_ROWS, CFG_DATA_BITS'($urandom_range(2)));
                1: program_reg(CFG_FRAME_ROWS, CFG_DATA_BITS'($urandom_range(12, 7)));
                default: program_reg(CFG_FRAME_ROWS, CFG_DATA_BITS'($urandom_range(6, 3)));
            endcase
            repeat ($urandom_range(3, 1)) send_frame(1'b1);
            phase_count++;
        end

        settle();
        $display("Covered %0d pixels and %0d frame totals over %0d random phases,",
                 sb.pixels_seen, sb.frames_checked, phase_count);
        $display("with clamped sizes, threshold extremes, mid-frame writes and a long stall.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
